/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ffbt_pkg.sv */
// ----------------------------------------------------------------------------
// ffbt_pkg
// Shared widths, register codes and types of the first-fit tournament tree
// ----------------------------------------------------------------------------
package ffbt_pkg;

	// default geometry
	localparam int BOXES_DEF    = 8;
	localparam int CAP_BITS_DEF = 16;

	// fixed field widths
	localparam int ID_W        = 16;
	localparam int SIZE_W      = 16;
	localparam int ROOM_W      = 16;
	localparam int BOX_IDX_W   = 3;
	localparam int CAPREG_W    = 16;
	localparam int USEDREG_W   = 4;
	localparam int CFG_IDX_W   = 8;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOX_CAPACITY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOXES_IN_USE = 8'd1;

	// register reset values
	localparam logic [CAPREG_W-1:0]  RESET_CAPACITY = 16'd32768;
	localparam logic [USEDREG_W-1:0] RESET_BOXES    = 4'd8;

	// walk sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_DOWN,
		ST_LEAF,
		ST_UP,
		ST_OUT
	} walk_state_t;

	// tree memory port controls
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

/* rtl/ffbt_mem.sv */
// ----------------------------------------------------------------------------
// ffbt_mem
// Tree node storage: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ffbt_mem #(
	parameter int DEPTH  = 15,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  ffbt_pkg::mem_ctl_t ctl,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);
	import ffbt_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/ffbt_fill.sv */
// ----------------------------------------------------------------------------
// ffbt_fill
// Configuration registers and the refill pass that rewrites every tree node
// ----------------------------------------------------------------------------
module ffbt_fill #(
	parameter int BOXES    = 8,
	parameter int CAP_BITS = 16,
	localparam int LVL     = $clog2(BOXES),
	localparam int NODES   = 2 * BOXES - 1,
	localparam int NODE_W  = $clog2(NODES)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffbt_pkg::CAPREG_W-1:0]  cfg_data,
	output logic                           busy,
	output logic [NODE_W-1:0]              wr_addr,
	output logic [CAP_BITS-1:0]            wr_data
);
	import ffbt_pkg::*;

	localparam int SPAN_W = LVL + 1;

	logic [CAPREG_W-1:0]  cap_q;
	logic [USEDREG_W-1:0] used_q;
	logic                 busy_q;
	logic [NODE_W-1:0]    node_q;
	logic [LVL-1:0]       left_q;
	logic [SPAN_W-1:0]    span_q;

	logic [31:0]          cap_w;
	logic [CAP_BITS-1:0]  cap_c;
	logic                 node_used;
	logic [SPAN_W-1:0]    left_next;
	logic                 level_end;
	logic                 cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// capacity masked to the tree width
	assign cap_w = 32'(cap_q);
	assign cap_c = cap_w[CAP_BITS-1:0];

	// a node holds capacity when the leftmost leaf below it is a used box
	assign node_used = 32'(left_q) < 32'(used_q);
	assign wr_data   = node_used ? cap_c : '0;
	assign wr_addr   = node_q;
	assign busy      = busy_q;

	// leftmost leaf of the next node on this level
	assign left_next = SPAN_W'(left_q) + span_q;
	assign level_end = left_next == SPAN_W'(BOXES);

	// register writes and pass sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= RESET_CAPACITY;
			used_q <= RESET_BOXES;
			busy_q <= 1'b1;
			node_q <= '0;
			left_q <= '0;
			span_q <= SPAN_W'(BOXES);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_BOX_CAPACITY: begin
					cap_q  <= cfg_data;
					busy_q <= 1'b1;
					node_q <= '0;
					left_q <= '0;
					span_q <= SPAN_W'(BOXES);
				end
				REG_BOXES_IN_USE: begin
					used_q <= cfg_data[USEDREG_W-1:0];
					busy_q <= 1'b1;
					node_q <= '0;
					left_q <= '0;
					span_q <= SPAN_W'(BOXES);
				end
				default: begin
				end
			endcase
		end else if (busy_q) begin
			if (node_q == NODE_W'(NODES - 1)) begin
				busy_q <= 1'b0;
			end
			node_q <= node_q + 1'b1;
			if (level_end) begin
				left_q <= '0;
				span_q <= span_q >> 1;
			end else begin
				left_q <= left_next[LVL-1:0];
			end
		end
	end

endmodule

/* rtl/ffbt_ctrl.sv */
// ----------------------------------------------------------------------------
// ffbt_ctrl
// Walk sequencer: descends the tree, updates the leaf, rebuilds maxima
// ----------------------------------------------------------------------------
module ffbt_ctrl #(
	parameter int BOXES    = 8,
	parameter int CAP_BITS = 16,
	localparam int NODES   = 2 * BOXES - 1,
	localparam int NODE_W  = $clog2(NODES)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ffbt_pkg::ID_W-1:0]      in_id,
	input  logic [ffbt_pkg::SIZE_W-1:0]    in_size,
	input  logic                           fill_busy,
	output ffbt_pkg::mem_ctl_t             mem_ctl,
	output logic [NODE_W-1:0]              rd_addr,
	output logic [NODE_W-1:0]              wr_addr,
	output logic [CAP_BITS-1:0]            wr_data,
	input  logic [CAP_BITS-1:0]            rd_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ffbt_pkg::ID_W-1:0]      out_tag,
	output logic                           out_placed,
	output logic [ffbt_pkg::BOX_IDX_W-1:0] out_box,
	output logic [ffbt_pkg::ROOM_W-1:0]    out_room
);
	import ffbt_pkg::*;

	walk_state_t state_q, state_d;

	logic [ID_W-1:0]      id_q;
	logic [CAP_BITS-1:0]  size_q;
	logic [NODE_W-1:0]    node_q;
	logic [CAP_BITS-1:0]  carry_q;
	logic                 res_placed_q;
	logic [BOX_IDX_W-1:0] res_box_q;
	logic [ROOM_W-1:0]    res_room_q;
	logic                 out_valid_q;
	logic [ID_W-1:0]      out_tag_q;
	logic                 out_placed_q;
	logic [BOX_IDX_W-1:0] out_box_q;
	logic [ROOM_W-1:0]    out_room_q;

	logic                 in_acc;
	logic                 out_load;
	logic [31:0]          size_w;
	logic [CAP_BITS-1:0]  cmp_b;
	logic                 ge;
	logic [NODE_W-1:0]    lchild;
	logic [NODE_W-1:0]    down_node;
	logic                 down_leaf;
	logic [NODE_W-1:0]    parent;
	logic                 parent_root;
	logic [NODE_W-1:0]    sib_node;
	logic [NODE_W-1:0]    sib_parent;
	logic [CAP_BITS-1:0]  diff;
	logic [CAP_BITS-1:0]  up_max;
	logic [31:0]          diff_w;
	logic [NODE_W-1:0]    box_n;
	logic [31:0]          box_w;

	assign in_ready = (state_q == ST_IDLE) && !fill_busy;
	assign in_acc   = in_valid & in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// item size masked to the tree width
	assign size_w = 32'(in_size);

	// shared comparator: fit test on the way down, max on the way up
	assign cmp_b = (state_q == ST_UP) ? carry_q : size_q;
	assign ge    = rd_data >= cmp_b;

	// tree index arithmetic
	assign lchild      = {node_q[NODE_W-2:0], 1'b1};
	assign down_node   = ge ? lchild : lchild + 1'b1;
	assign down_leaf   = down_node >= NODE_W'(BOXES - 1);
	assign parent      = (node_q - 1'b1) >> 1;
	assign parent_root = parent == '0;
	assign sib_node    = node_q[0] ? node_q + 1'b1 : node_q - 1'b1;
	assign sib_parent  = parent[0] ? parent + 1'b1 : parent - 1'b1;

	// leaf update and path maximum
	assign diff   = rd_data - size_q;
	assign up_max = ge ? rd_data : carry_q;
	assign diff_w = 32'(diff);
	assign box_n  = node_q - NODE_W'(BOXES - 1);
	assign box_w  = 32'(box_n);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				state_d = ge ? ST_DOWN : ST_OUT;
			end
			ST_DOWN: begin
				if (down_leaf) state_d = ST_LEAF;
			end
			ST_LEAF: begin
				state_d = ST_UP;
			end
			ST_UP: begin
				if (parent_root) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory port controls per state
	always_comb begin
		mem_ctl = '0;
		rd_addr = '0;
		wr_addr = node_q;
		wr_data = diff;
		unique case (state_q)
			ST_IDLE: begin
				mem_ctl.re = in_acc;
			end
			ST_ROOT: begin
				mem_ctl.re = ge;
				rd_addr    = NODE_W'(1);
			end
			ST_DOWN: begin
				mem_ctl.re = 1'b1;
				rd_addr    = down_leaf ? down_node : {down_node[NODE_W-2:0], 1'b1};
			end
			ST_LEAF: begin
				mem_ctl.we = 1'b1;
				mem_ctl.re = 1'b1;
				rd_addr    = sib_node;
			end
			ST_UP: begin
				mem_ctl.we = 1'b1;
				mem_ctl.re = !parent_root;
				rd_addr    = sib_parent;
				wr_addr    = parent;
				wr_data    = up_max;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					id_q   <= in_id;
					size_q <= size_w[CAP_BITS-1:0];
				end
			end
			ST_ROOT: begin
				node_q       <= '0;
				res_placed_q <= 1'b0;
				res_box_q    <= '0;
				res_room_q   <= '0;
			end
			ST_DOWN: begin
				node_q <= down_node;
			end
			ST_LEAF: begin
				carry_q      <= diff;
				res_placed_q <= 1'b1;
				res_box_q    <= box_w[BOX_IDX_W-1:0];
				res_room_q   <= diff_w[ROOM_W-1:0];
			end
			ST_UP: begin
				carry_q <= up_max;
				node_q  <= parent;
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_tag_q    <= id_q;
			out_placed_q <= res_placed_q;
			out_box_q    <= res_box_q;
			out_room_q   <= res_room_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_tag    = out_tag_q;
	assign out_placed = out_placed_q;
	assign out_box    = out_box_q;
	assign out_room   = out_room_q;

endmodule

/* rtl/first_fit_bin_tournament_tree_core.sv */
// ----------------------------------------------------------------------------
// first_fit_bin_tournament_tree_core
// First-fit box allocator on a max tree held in a single-port-pair memory
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: item_id, item_size
//  m_axis    out        tdata: item_tag, box_index, room_left; tuser: placed
//  cfg       in         cfg_index selects the register, cfg_data is written
//
//  an item walks from accept to result in these steps: root compare, one read
//  per level down, leaf write, one read and write per level up, output load;
//  an item that fits nowhere goes from the root compare to the output load.
//  the next item is taken only after the result is loaded.
//  after reset and after each write to the capacity or boxes-in-use register a
//  refill pass rewrites every node; no item is accepted until it is done.
//  a result stalled in the output register holds the next item in its last step.
// ----------------------------------------------------------------------------
module first_fit_bin_tournament_tree_core #(
	parameter int BOXES    = ffbt_pkg::BOXES_DEF,
	parameter int CAP_BITS = ffbt_pkg::CAP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// item_id[15:0], item_size[31:16]
	input  logic [ffbt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// item_tag[15:0], box_index[18:16], room_left[34:19], zero fill above
	output logic [ffbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// placed[0]
	output logic [ffbt_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ffbt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffbt_pkg::CAPREG_W-1:0]    cfg_data
);
	import ffbt_pkg::*;

	localparam int NODES  = 2 * BOXES - 1;
	localparam int NODE_W = $clog2(NODES);

	logic                 fill_busy;
	logic [NODE_W-1:0]    fill_addr;
	logic [CAP_BITS-1:0]  fill_data;
	mem_ctl_t             walk_ctl;
	mem_ctl_t             mem_ctl;
	logic [NODE_W-1:0]    walk_rd_addr;
	logic [NODE_W-1:0]    walk_wr_addr;
	logic [CAP_BITS-1:0]  walk_wr_data;
	logic [NODE_W-1:0]    mem_wr_addr;
	logic [CAP_BITS-1:0]  mem_wr_data;
	logic [CAP_BITS-1:0]  mem_rd_data;
	logic [ID_W-1:0]      res_tag;
	logic                 res_placed;
	logic [BOX_IDX_W-1:0] res_box;
	logic [ROOM_W-1:0]    res_room;

	// configuration and refill pass
	ffbt_fill #(
		.BOXES    (BOXES),
		.CAP_BITS (CAP_BITS)
	) u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (fill_busy),
		.wr_addr   (fill_addr),
		.wr_data   (fill_data)
	);

	// walk sequencer
	ffbt_ctrl #(
		.BOXES    (BOXES),
		.CAP_BITS (CAP_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_id      (s_axis_tdata[ID_W-1:0]),
		.in_size    (s_axis_tdata[ID_W+SIZE_W-1:ID_W]),
		.fill_busy  (fill_busy),
		.mem_ctl    (walk_ctl),
		.rd_addr    (walk_rd_addr),
		.wr_addr    (walk_wr_addr),
		.wr_data    (walk_wr_data),
		.rd_data    (mem_rd_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_tag    (res_tag),
		.out_placed (res_placed),
		.out_box    (res_box),
		.out_room   (res_room)
	);

	// refill owns the write port while it runs
	always_comb begin
		if (fill_busy) begin
			mem_ctl.we  = 1'b1;
			mem_ctl.re  = 1'b0;
			mem_wr_addr = fill_addr;
			mem_wr_data = fill_data;
		end else begin
			mem_ctl     = walk_ctl;
			mem_wr_addr = walk_wr_addr;
			mem_wr_data = walk_wr_data;
		end
	end

	// tree node storage
	ffbt_mem #(
		.DEPTH  (NODES),
		.ADDR_W (NODE_W),
		.DATA_W (CAP_BITS)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (walk_rd_addr),
		.rd_data (mem_rd_data)
	);

	// result packing
	assign m_axis_tdata = {
		(OUT_TDATA_W - ID_W - BOX_IDX_W - ROOM_W)'(0),
		res_room,
		res_box,
		res_tag
	};
	assign m_axis_tuser = res_placed;

endmodule

/* rtl/ffbt_chk.sv */
// ----------------------------------------------------------------------------
// ffbt_chk
// Port-level checks on the first-fit tournament tree core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffbt_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [ffbt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ffbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [ffbt_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [ffbt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [ffbt_pkg::CAPREG_W-1:0]    cfg_data
);
	import ffbt_pkg::*;

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

	// one item at a time: no accept right after an accept
	`ASSERT_NEXT(a_one_item, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accept")

	// a register write starts a refill, so no item is taken next cycle
	`ASSERT_NEXT(a_cfg_refill, clk, arst_n, cfg_valid && cfg_ready && (cfg_index == REG_BOX_CAPACITY || cfg_index == REG_BOXES_IN_USE), !s_axis_tready, "input ready during refill")

	// a rejected item reports box zero and no room
	`ASSERT_SAME(a_reject_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[OUT_TDATA_W-1:ID_W] == '0, "rejected result carries box or room")

endmodule

bind first_fit_bin_tournament_tree_core ffbt_chk u_ffbt_chk (.*);
